// File: sv/pcs_pkg.sv
// Shared widths, reset values, register codes and stage structures of the crosstalk stencil.
`default_nettype none

package pcs_pkg;

    localparam int HIT_W       = 16;
    localparam int WEIGHT_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int SIDE_W      = 4;
    localparam int ROW_W       = SIDE_W + 1;
    localparam int IDX_W       = 6;
    localparam int SUM_W       = HIT_W + 2;
    localparam int PROD_W      = SUM_W + WEIGHT_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_SIDE = 8;

    localparam logic [SIDE_W-1:0]   SIDE_RESET          = 4'd8;
    localparam logic [SIDE_W-1:0]   SIDE_MIN            = 4'd2;
    localparam logic [WEIGHT_W-1:0] EDGE_WEIGHT_RESET   = 16'd655;
    localparam logic [WEIGHT_W-1:0] CORNER_WEIGHT_RESET = 16'd66;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_SIDE   = 2'd0,
        CFG_EDGE_WEIGHT   = 2'd1,
        CFG_CORNER_WEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nbr_mask_t;

    typedef struct packed {
        logic              is_pixel;
        logic              emit;
        logic              run_last;
        nbr_mask_t         mask;
        logic [SIDE_W-1:0] col;
        logic [IDX_W-1:0]  index;
        logic [HIT_W-1:0]  hit;
    } slot_t;

    typedef struct packed {
        logic [SUM_W-1:0] edges;
        logic [SUM_W-1:0] corners;
        logic [HIT_W-1:0] center;
        logic [IDX_W-1:0] index;
        logic             run_last;
    } sums_t;

endpackage

`default_nettype wire

// File: sv/pcs_if.sv
// Valid/ready request channels for incoming hit counts and outgoing smeared counts.
`default_nettype none

interface pcs_in_if;
    import pcs_pkg::*;

    logic             valid;
    logic             ready;
    logic [HIT_W-1:0] hit_count;

    modport source (output valid, output hit_count, input ready);
    modport sink (input valid, input hit_count, output ready);
endinterface

interface pcs_out_if;
    import pcs_pkg::*;

    logic             valid;
    logic             ready;
    logic [HIT_W-1:0] smeared_count;
    logic [IDX_W-1:0] pixel_index;
    logic             run_last;

    modport source (output valid, output smeared_count, output pixel_index, output run_last,
                    input ready);
    modport sink (input valid, input smeared_count, input pixel_index, input run_last,
                  output ready);
endinterface

`default_nettype wire

// File: sv/pcs_seq.sv
// Raster position sequencer: issues pixel slots and the flush slots that close a frame.
`default_nettype none

module pcs_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pcs_pkg::SIDE_W-1:0] side,
    input  logic                       restart,
    input  logic                       in_valid,
    input  logic [pcs_pkg::HIT_W-1:0]  hit_count,
    input  logic                       slot_free,
    output logic                       in_ready,
    output logic                       slot_valid,
    output pcs_pkg::slot_t             slot
);
    import pcs_pkg::*;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [SIDE_W-1:0] col_reg;
    logic [SIDE_W-1:0] col_next;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic [ROW_W-1:0]  side_w;
    logic [SIDE_W-1:0] side_m1;
    logic              flushing;
    logic              final_slot;
    logic              frame_end;
    logic              emit;
    logic [ROW_W-1:0]  er;
    logic [SIDE_W-1:0] ec;

    assign side_w     = ROW_W'(side);
    assign side_m1    = side - SIDE_W'(1);
    assign flushing   = row_reg >= side_w;
    assign final_slot = row_reg == (side_w + ROW_W'(1));
    assign frame_end  = (row_reg == ROW_W'(side_m1)) && (col_reg == side_m1);
    assign emit       = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign in_ready   = slot_free && !flushing && !restart;
    assign slot_valid = slot_free && !restart && (flushing || in_valid);

    // The pixel that leaves with this slot sits one row up and one column left.
    always_comb
    begin
        if (col_reg != '0)
        begin
            er = row_reg - ROW_W'(1);
            ec = col_reg - SIDE_W'(1);
        end
        else
        begin
            er = row_reg - ROW_W'(2);
            ec = side_m1;
        end
    end

    always_comb
    begin
        slot.is_pixel   = !flushing;
        slot.emit       = emit;
        slot.run_last   = (!flushing && !frame_end) || final_slot;
        slot.mask.up    = er != '0;
        slot.mask.down  = er < ROW_W'(side_m1);
        slot.mask.left  = ec != '0;
        slot.mask.right = ec != side_m1;
        slot.col        = col_reg;
        slot.index      = index_reg;
        slot.hit        = flushing ? '0 : hit_count;
    end

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        index_next = index_reg;
        if (restart)
        begin
            row_next   = '0;
            col_next   = '0;
            index_next = '0;
        end
        else if (slot_valid)
        begin
            if (final_slot)
            begin
                row_next   = '0;
                col_next   = '0;
                index_next = '0;
            end
            else
            begin
                if (col_reg == side_m1)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + SIDE_W'(1);
                end
                if (emit)
                begin
                    index_next = index_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            index_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            index_reg <= index_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/pcs_window.sv
// Two-row line memory with read-modify-write, 3x3 column window and masked neighbour sums.
`default_nettype none

module pcs_window #(
    parameter int MAX_SIDE = pcs_pkg::DEF_MAX_SIDE
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           slot_valid,
    input  pcs_pkg::slot_t slot,
    output logic           slot_free,
    input  logic           sum_ready,
    output logic           sum_valid,
    output pcs_pkg::sums_t sums
);
    import pcs_pkg::*;

    localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    typedef struct packed {
        logic [HIT_W-1:0] above2;
        logic [HIT_W-1:0] above1;
    } line_pair_t;

    typedef struct packed {
        logic [HIT_W-1:0] top;
        logic [HIT_W-1:0] mid;
        logic [HIT_W-1:0] bot;
    } column_t;

    line_pair_t        line_mem [MAX_SIDE];
    line_pair_t        rd_reg;
    slot_t             slot_reg;
    logic              b_valid_reg;
    column_t           win1_reg;
    column_t           win2_reg;
    column_t           fresh;
    logic              sum_valid_reg;
    sums_t             sums_reg;
    sums_t             sums_next;
    logic              b_go;
    logic              s_free;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    function automatic logic [SUM_W-1:0] pick(input logic en, input logic [HIT_W-1:0] v);
        return en ? SUM_W'(v) : '0;
    endfunction

    assign s_free    = !sum_valid_reg || sum_ready;
    assign b_go      = b_valid_reg && (!slot_reg.emit || s_free);
    assign slot_free = !b_valid_reg || b_go;
    assign rd_addr   = ADDR_W'(slot.col);
    assign wr_addr   = ADDR_W'(slot_reg.col);
    assign sum_valid = sum_valid_reg;
    assign sums      = sums_reg;

    assign fresh.top = rd_reg.above2;
    assign fresh.mid = rd_reg.above1;
    assign fresh.bot = slot_reg.hit;

    // Left column is the older window entry, centre the newer, right the column just read.
    always_comb
    begin
        sums_next.edges   = pick(slot_reg.mask.up, win1_reg.top)
                          + pick(slot_reg.mask.down, win1_reg.bot)
                          + pick(slot_reg.mask.left, win2_reg.mid)
                          + pick(slot_reg.mask.right, fresh.mid);
        sums_next.corners = pick(slot_reg.mask.up && slot_reg.mask.left, win2_reg.top)
                          + pick(slot_reg.mask.down && slot_reg.mask.left, win2_reg.bot)
                          + pick(slot_reg.mask.up && slot_reg.mask.right, fresh.top)
                          + pick(slot_reg.mask.down && slot_reg.mask.right, fresh.bot);
        sums_next.center   = win1_reg.mid;
        sums_next.index    = slot_reg.index;
        sums_next.run_last = slot_reg.run_last;
    end

    always_ff @(posedge clk)
    begin
        if (slot_valid)
        begin
            rd_reg <= line_mem[rd_addr];
        end
        if (b_go && slot_reg.is_pixel)
        begin
            line_mem[wr_addr] <= '{above2: rd_reg.above1, above1: slot_reg.hit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_valid)
        begin
            slot_reg <= slot;
        end
        if (b_go)
        begin
            win2_reg <= win1_reg;
            win1_reg <= fresh;
        end
        if (b_go && slot_reg.emit)
        begin
            sums_reg <= sums_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (slot_free)
            begin
                b_valid_reg <= slot_valid;
            end
            if (s_free)
            begin
                sum_valid_reg <= b_go && slot_reg.emit;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/pcs_mac.sv
// Weight multiply, floor of the Q0.16 share, saturating add and the output register.
`default_nettype none

module pcs_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sum_valid,
    input  pcs_pkg::sums_t               sums,
    output logic                         sum_ready,
    input  logic [pcs_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic [pcs_pkg::WEIGHT_W-1:0] corner_weight,
    pcs_out_if.source                    pixel_out
);
    import pcs_pkg::*;

    localparam int SHARE_W = PROD_W - FRAC_W + 1;
    localparam int TOTAL_W = SHARE_W + 1;

    typedef struct packed {
        logic [PROD_W-1:0] edge_prod;
        logic [PROD_W-1:0] corner_prod;
        logic [HIT_W-1:0]  center;
        logic [IDX_W-1:0]  index;
        logic              run_last;
    } prod_t;

    logic               prod_valid_reg;
    prod_t              prod_reg;
    logic               out_valid_reg;
    logic [HIT_W-1:0]   smeared_reg;
    logic [HIT_W-1:0]   smeared_next;
    logic [IDX_W-1:0]   index_reg;
    logic               run_last_reg;
    logic               out_free;
    logic               prod_go;
    logic [PROD_W:0]    share_full;
    logic [SHARE_W-1:0] share;
    logic [TOTAL_W-1:0] total;

    assign out_free  = !out_valid_reg || pixel_out.ready;
    assign prod_go   = prod_valid_reg && out_free;
    assign sum_ready = !prod_valid_reg || prod_go;

    assign share_full   = {1'b0, prod_reg.edge_prod} + {1'b0, prod_reg.corner_prod};
    assign share        = share_full[PROD_W:FRAC_W];
    assign total        = {1'b0, share} + TOTAL_W'(prod_reg.center);
    assign smeared_next = (total[TOTAL_W-1:HIT_W] != '0) ? '1 : total[HIT_W-1:0];

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.smeared_count = smeared_reg;
    assign pixel_out.pixel_index   = index_reg;
    assign pixel_out.run_last      = run_last_reg;

    always_ff @(posedge clk)
    begin
        if (sum_valid && sum_ready)
        begin
            prod_reg.edge_prod   <= PROD_W'(sums.edges) * PROD_W'(edge_weight);
            prod_reg.corner_prod <= PROD_W'(sums.corners) * PROD_W'(corner_weight);
            prod_reg.center      <= sums.center;
            prod_reg.index       <= sums.index;
            prod_reg.run_last    <= sums.run_last;
        end
        if (prod_go)
        begin
            smeared_reg  <= smeared_next;
            index_reg    <= prod_reg.index;
            run_last_reg <= prod_reg.run_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sum_ready)
            begin
                prod_valid_reg <= sum_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/pixel_crosstalk_stencil.sv
// Top level of the pixel crosstalk stencil: configuration registers and the request pipeline.
//
// Hit counts of an active_side x active_side grid enter on pixel_in, one request per pixel
// in raster order. Each pixel leaves on pixel_out with its own count plus the floored
// weighted share of its in-grid edge and corner neighbours, saturated at 65535, together
// with its raster index. A pixel leaves once the pixel below and to its right has entered;
// run_last marks the last result caused by an input request.
// Throughput is one pixel per cycle while pixel_out is ready and no flush holds pixel_in.
// An emitting input passes line memory read, neighbour sums, weight products and output
// register on its way to pixel_out. The last pixel of a frame releases side + 2 results,
// and pixel_in is held off while the remaining two rows are read back from the line memory.
// Writes go through cfg_wr_en, cfg_index and cfg_data; writing active_side restarts the frame.
// Reset restores the register defaults and an empty pipeline at the start of a frame; the
// line memory is not cleared, since rows outside the frame are masked off.
// When pixel_out stalls, the four stages fill up before pixel_in drops ready.
`default_nettype none

module pixel_crosstalk_stencil #(
    parameter int MAX_SIDE = pcs_pkg::DEF_MAX_SIDE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pcs_in_if.sink                          pixel_in,
    pcs_out_if.source                       pixel_out,
    input  logic                            cfg_wr_en,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcs_pkg::*;

    localparam int SIDE_CAP = (MAX_SIDE < (2 ** SIDE_W) - 1) ? MAX_SIDE : (2 ** SIDE_W) - 1;

    logic [SIDE_W-1:0]   active_side_reg;
    logic [WEIGHT_W-1:0] edge_weight_reg;
    logic [WEIGHT_W-1:0] corner_weight_reg;
    logic [SIDE_W-1:0]   side;
    logic                restart;
    logic                slot_free;
    logic                slot_valid;
    slot_t               slot;
    logic                sum_valid;
    logic                sum_ready;
    sums_t               sums;

    assign restart = cfg_wr_en && (cfg_index == CFG_ACTIVE_SIDE);

    always_comb
    begin
        if (active_side_reg < SIDE_MIN)
        begin
            side = SIDE_MIN;
        end
        else if (active_side_reg > SIDE_W'(SIDE_CAP))
        begin
            side = SIDE_W'(SIDE_CAP);
        end
        else
        begin
            side = active_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_side_reg   <= SIDE_RESET;
            edge_weight_reg   <= EDGE_WEIGHT_RESET;
            corner_weight_reg <= CORNER_WEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_SIDE:   active_side_reg   <= cfg_data[SIDE_W-1:0];
                CFG_EDGE_WEIGHT:   edge_weight_reg   <= cfg_data[WEIGHT_W-1:0];
                CFG_CORNER_WEIGHT: corner_weight_reg <= cfg_data[WEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    pcs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side),
        .restart    (restart),
        .in_valid   (pixel_in.valid),
        .hit_count  (pixel_in.hit_count),
        .slot_free  (slot_free),
        .in_ready   (pixel_in.ready),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    pcs_window #(
        .MAX_SIDE (MAX_SIDE)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_free  (slot_free),
        .sum_ready  (sum_ready),
        .sum_valid  (sum_valid),
        .sums       (sums)
    );

    pcs_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .sum_valid     (sum_valid),
        .sums          (sums),
        .sum_ready     (sum_ready),
        .edge_weight   (edge_weight_reg),
        .corner_weight (corner_weight_reg),
        .pixel_out     (pixel_out)
    );

endmodule

`default_nettype wire
